@@ rtl/pncs_pkg.sv @@
// ----------------------------------------------------------------------------
// Palette nearest color search package
// Shared types, weights and helpers for the palette search block.
// ----------------------------------------------------------------------------
`default_nettype none

package pncs_pkg;

    localparam int CH_W    = 5;
    localparam int IDX_W   = 8;
    localparam int MASK_W  = 9;
    localparam int CNT_W   = 9;
    localparam int SQ_W    = 10;
    localparam int COST_W  = 23;
    localparam int DRAIN_W = 2;

    // Cycles from address issue to a registered cost.
    localparam int PIPE_LAT = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [COST_W-1:0] t_cost;
    typedef logic [SQ_W-1:0]   t_sq;

    typedef struct packed {
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
    } t_color5;

    typedef struct packed {
        logic vld;
        logic skip;
        t_idx idx;
    } t_tag;

    localparam t_color5 RESET_COLOR = '{a: 5'd31, b: 5'd0, g: 5'd0, r: 5'd0};

    localparam t_cost W_GREEN = t_cost'(59 * 59);
    localparam t_cost W_RED   = t_cost'(30 * 30);
    localparam t_cost W_BLUE  = t_cost'(11 * 11);
    localparam t_cost W_ALPHA = t_cost'(8 * 8);

    function automatic t_sq sq_diff5(input logic [CH_W-1:0] x, input logic [CH_W-1:0] y);
        logic [CH_W-1:0] d;
        d = (x >= y) ? (x - y) : (y - x);
        return t_sq'(d) * t_sq'(d);
    endfunction

endpackage

`default_nettype wire

@@ rtl/pncs_palette_mem.sv @@
// ----------------------------------------------------------------------------
// Palette entry memory
// One write port and one registered read port; unwritten entries read as
// opaque black.
// ----------------------------------------------------------------------------
`default_nettype none

module pncs_palette_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_wen,
    input  wire  [AW-1:0]          i_waddr,
    input  pncs_pkg::t_color5      i_wdata,
    input  wire  [AW-1:0]          i_raddr,
    output pncs_pkg::t_color5      o_rdata
);

    pncs_pkg::t_color5 r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    pncs_pkg::t_color5 r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wen) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : pncs_pkg::RESET_COLOR;

endmodule

`default_nettype wire

@@ rtl/pncs_cost_unit.sv @@
// ----------------------------------------------------------------------------
// Weighted color cost unit
// Two-stage pipeline: squared channel differences, then the weighted sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pncs_cost_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pncs_pkg::t_color5    i_entry,
    input  pncs_pkg::t_color5    i_query,
    input  pncs_pkg::t_tag       i_tag,
    output pncs_pkg::t_cost      o_cost,
    output pncs_pkg::t_tag       o_tag
);

    pncs_pkg::t_sq   r_sq_r;
    pncs_pkg::t_sq   r_sq_g;
    pncs_pkg::t_sq   r_sq_b;
    pncs_pkg::t_sq   r_sq_a;
    pncs_pkg::t_tag  r_tag_sq;
    pncs_pkg::t_cost r_cost;
    pncs_pkg::t_tag  r_tag_cost;

    always_ff @(posedge i_clk) begin
        r_sq_r <= pncs_pkg::sq_diff5(i_entry.r, i_query.r);
        r_sq_g <= pncs_pkg::sq_diff5(i_entry.g, i_query.g);
        r_sq_b <= pncs_pkg::sq_diff5(i_entry.b, i_query.b);
        r_sq_a <= pncs_pkg::sq_diff5(i_entry.a, i_query.a);
        r_cost <= pncs_pkg::W_GREEN * pncs_pkg::t_cost'(r_sq_g)
                + pncs_pkg::W_RED   * pncs_pkg::t_cost'(r_sq_r)
                + pncs_pkg::W_BLUE  * pncs_pkg::t_cost'(r_sq_b)
                + pncs_pkg::W_ALPHA * pncs_pkg::t_cost'(r_sq_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_sq   <= '0;
            r_tag_cost <= '0;
        end else begin
            r_tag_sq   <= i_tag;
            r_tag_cost <= r_tag_sq;
        end
    end

    assign o_cost = r_cost;
    assign o_tag  = r_tag_cost;

endmodule

`default_nettype wire

@@ rtl/palette_nearest_color_search_top.sv @@
// ----------------------------------------------------------------------------
// Palette nearest color search
// Holds a palette of RGBA entries and answers best-fit queries. A write
// request stores one entry and gives no result. A query request scans the
// entries in use, min(palette_count, PALETTE_DEPTH) of them, one per cycle
// through a shared weighted cost pipeline, paced by the single read port of
// the palette memory, and returns the first index of lowest cost. A
// transparent query with a mask index returns that index without a scan.
// The input is not ready while a query is in progress. The result waits in
// an output register, and a new request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_nearest_color_search_top #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wen,
    input  wire  [8:0]  i_cfg_wdata,    // palette_count
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24], alpha[39:32],
    // skip_slot[48:40], zero[55:49]
    input  wire  [55:0] s_axis_tdata,
    input  wire         s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata    // best_index
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int CH_W = pncs_pkg::CH_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                      r_state, n_state;
    logic [pncs_pkg::CNT_W-1:0]      r_count;
    logic [CW-1:0]                   r_issue, n_issue;
    logic [CW-1:0]                   r_n, n_n;
    logic [pncs_pkg::DRAIN_W-1:0]    r_drain, n_drain;
    pncs_pkg::t_color5               r_q, n_q;
    logic                            r_has_mask, n_has_mask;
    pncs_pkg::t_idx                  r_mask, n_mask;
    logic                            r_found, n_found;
    pncs_pkg::t_cost                 r_lowest, n_lowest;
    pncs_pkg::t_idx                  r_best, n_best;
    logic                            r_out_vld, n_out_vld;
    pncs_pkg::t_idx                  r_out_idx, n_out_idx;
    pncs_pkg::t_tag                  r_mem_tag;

    pncs_pkg::t_tag                  w_iss_tag;
    pncs_pkg::t_color5               w_in_color;
    pncs_pkg::t_idx                  w_in_index;
    logic [pncs_pkg::MASK_W-1:0]     w_in_mask;
    logic                            w_accept;
    logic                            w_wen;
    pncs_pkg::t_color5               w_rdata;
    pncs_pkg::t_cost                 w_cost;
    pncs_pkg::t_tag                  w_cost_tag;
    logic [CW-1:0]                   w_n_eff;

    assign w_in_index   = s_axis_tdata[7:0];
    assign w_in_color.r = s_axis_tdata[15:11];
    assign w_in_color.g = s_axis_tdata[23:19];
    assign w_in_color.b = s_axis_tdata[31:27];
    assign w_in_color.a = s_axis_tdata[39:35];
    assign w_in_mask    = s_axis_tdata[48:40];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_wen         = w_accept && (s_axis_tuser == pncs_pkg::OP_WRITE)
                        && (9'(w_in_index) < 9'(PALETTE_DEPTH));
    assign w_n_eff       = (r_count > 9'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                         : r_count[CW-1:0];

    pncs_palette_mem #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wen   (w_wen),
        .i_waddr (w_in_index[AW-1:0]),
        .i_wdata (w_in_color),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (w_rdata)
    );

    pncs_cost_unit u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (w_rdata),
        .i_query (r_q),
        .i_tag   (r_mem_tag),
        .o_cost  (w_cost),
        .o_tag   (w_cost_tag)
    );

    always_comb begin
        n_state    = r_state;
        n_issue    = r_issue;
        n_n        = r_n;
        n_drain    = r_drain;
        n_q        = r_q;
        n_has_mask = r_has_mask;
        n_mask     = r_mask;
        n_found    = r_found;
        n_lowest   = r_lowest;
        n_best     = r_best;
        n_out_vld  = r_out_vld;
        n_out_idx  = r_out_idx;
        w_iss_tag  = '0;

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        if (w_cost_tag.vld && !w_cost_tag.skip && (!r_found || w_cost < r_lowest)) begin
            n_found  = 1'b1;
            n_lowest = w_cost;
            n_best   = w_cost_tag.idx;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept && (s_axis_tuser == pncs_pkg::OP_QUERY)) begin
                    n_q        = w_in_color;
                    n_has_mask = !w_in_mask[pncs_pkg::MASK_W-1];
                    n_mask     = w_in_mask[pncs_pkg::IDX_W-1:0];
                    n_found    = 1'b0;
                    n_best     = '0;
                    n_issue    = '0;
                    n_n        = w_n_eff;
                    if ((w_in_color.a == CH_W'(0)) && !w_in_mask[pncs_pkg::MASK_W-1]) begin
                        n_best  = w_in_mask[pncs_pkg::IDX_W-1:0];
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_issue == r_n) begin
                    n_drain = pncs_pkg::DRAIN_W'(pncs_pkg::PIPE_LAT);
                    n_state = ST_DRAIN;
                end else begin
                    w_iss_tag.vld  = 1'b1;
                    w_iss_tag.idx  = pncs_pkg::t_idx'(r_issue[AW-1:0]);
                    w_iss_tag.skip = r_has_mask
                                  && (pncs_pkg::t_idx'(r_issue[AW-1:0]) == r_mask);
                    n_issue        = r_issue + CW'(1);
                end
            end
            ST_DRAIN: begin
                if (r_drain == pncs_pkg::DRAIN_W'(1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_drain = r_drain - pncs_pkg::DRAIN_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld = 1'b1;
                    n_out_idx = r_best;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= 9'd256;
            r_out_vld <= 1'b0;
            r_mem_tag <= '0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_mem_tag <= w_iss_tag;
            r_found   <= n_found;
            if (i_cfg_wen) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue    <= n_issue;
        r_n        <= n_n;
        r_drain    <= n_drain;
        r_q        <= n_q;
        r_has_mask <= n_has_mask;
        r_mask     <= n_mask;
        r_lowest   <= n_lowest;
        r_best     <= n_best;
        r_out_idx  <= n_out_idx;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_idx;

`ifndef SYNTH
    // Costs arrive only for entries inside the active scan range.
    a_cost_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cost_tag.vld |-> (9'(w_cost_tag.idx) < 9'(r_n)))
        else $error("cost returned for an index outside the scan range");

    // Nothing is in flight once the block is idle or holding a result.
    a_no_stray_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cost_tag.vld |-> (r_state == ST_SCAN || r_state == ST_DRAIN))
        else $error("cost pipeline active outside a scan");

    // A searched answer never picks the masked entry.
    a_mask_skipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_found && r_has_mask) |-> (r_best != r_mask))
        else $error("masked entry selected as best fit");

    // The issue counter never runs past the entry count.
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issue <= r_n))
        else $error("scan issued past the palette count");
`endif

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Palette nearest color search testbench
// Drives write and query requests into the palette search block through its
// stream ports and checks every returned index against a listed result or
// a predictor that keeps its own palette and entry count. A short table of
// directed requests comes first, then random phases at several palette
// counts, with random request and result idles outside one calm phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int          LIMIT_CYCLES   = 1_000_000;
    localparam int          DRAIN_CYCLES   = 300;
    localparam int          CFG_GAP        = 16;
    localparam int          ITEMS_PER_SET  = 78;
    localparam logic [8:0]  NO_MASK        = 9'h1FF;
    localparam logic [8:0]  LOW_NEG_MASK   = 9'h100;

    typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  idx;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [8:0]  mask;
        logic [8:0]  cnt;
        logic        typed;
        logic [7:0]  res;
    } t_dir_row;

    localparam int DIR_N = 24;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{ROW_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255, NO_MASK,      9'd0,   1'b1, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   9'd5,         9'd0,   1'b1, 8'd5},
        '{ROW_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 8'd7,   9'd255,       9'd0,   1'b1, 8'd255},
        '{ROW_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   NO_MASK,      9'd0,   1'b1, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   LOW_NEG_MASK, 9'd0,   1'b1, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 9'd0,         9'd0,   1'b1, 8'd1},
        '{ROW_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, NO_MASK,      9'd0,   1'b0, 8'd0},
        '{ROW_WRITE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   NO_MASK,      9'd0,   1'b0, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255, NO_MASK,      9'd0,   1'b1, 8'd255},
        '{ROW_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 9'd255,       9'd0,   1'b0, 8'd0},
        '{ROW_WRITE, 8'd3,   8'd248, 8'd7,   8'd128, 8'd200, NO_MASK,      9'd0,   1'b0, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd250, 8'd3,   8'd130, 8'd206, NO_MASK,      9'd0,   1'b0, 8'd0},
        '{ROW_WRITE, 8'd128, 8'd10,  8'd250, 8'd3,   8'd64,  NO_MASK,      9'd0,   1'b0, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd12,  8'd255, 8'd0,   8'd70,  9'd3,         9'd0,   1'b0, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   8'd8,   9'd255,       9'd0,   1'b0, 8'd0},
        '{ROW_CFG,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   NO_MASK,      9'd0,   1'b0, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd128, 8'd128, 8'd128, 8'd128, NO_MASK,      9'd0,   1'b1, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd128, 8'd128, 8'd128, 8'd0,   9'd200,       9'd0,   1'b1, 8'd200},
        '{ROW_CFG,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   NO_MASK,      9'd1,   1'b0, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 9'd0,         9'd0,   1'b1, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 9'd1,         9'd0,   1'b1, 8'd0},
        '{ROW_CFG,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   NO_MASK,      9'd511, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255, NO_MASK,      9'd0,   1'b1, 8'd255},
        '{ROW_CFG,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   NO_MASK,      9'd256, 1'b0, 8'd0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wen     = 1'b0;
    logic [8:0]  i_cfg_wdata   = 9'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = 56'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    logic        req_typed     = 1'b0;
    logic [7:0]  req_res       = 8'd0;
    bit          calm          = 1'b0;

    logic [7:0]  pal_r [256];
    logic [7:0]  pal_g [256];
    logic [7:0]  pal_b [256];
    logic [7:0]  pal_a [256];
    int unsigned count_model;
    logic [7:0]  pending_index [$];
    int          err_cnt = 0;
    int          cycles  = 0;

    palette_nearest_color_search_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 6);
    end

    function automatic int unsigned sq5(input logic [4:0] x, input logic [4:0] y);
        int d;
        d = int'(x) - int'(y);
        return d * d;
    endfunction

    function automatic logic [7:0] nearest_index(input logic [7:0] qr, input logic [7:0] qg,
                                                 input logic [7:0] qb, input logic [7:0] qa,
                                                 input logic [8:0] qmask);
        logic [4:0]  r5, g5, b5, a5;
        logic        masked;
        int unsigned lim, cost, lowest;
        logic [7:0]  best;
        bit          found;
        r5 = qr[7:3];
        g5 = qg[7:3];
        b5 = qb[7:3];
        a5 = qa[7:3];
        masked = !qmask[8];
        if (a5 == 5'd0 && masked) begin
            return qmask[7:0];
        end
        lim = (count_model > 256) ? 256 : count_model;
        best = 8'd0;
        lowest = 0;
        found = 1'b0;
        for (int i = 0; i < lim; i++) begin
            if (!(masked && i == int'(qmask[7:0]))) begin
                cost = 3481 * sq5(pal_g[i][7:3], g5) + 900 * sq5(pal_r[i][7:3], r5)
                     + 121 * sq5(pal_b[i][7:3], b5) + 64 * sq5(pal_a[i][7:3], a5);
                if (!found || cost < lowest) begin
                    found = 1'b1;
                    lowest = cost;
                    best = 8'(i);
                end
            end
        end
        return best;
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("ERROR at cycle %0d: %s", cycles, msg);
        end
    endtask

    initial begin
        for (int i = 0; i < 256; i++) begin
            pal_r[i] = 8'd0;
            pal_g[i] = 8'd0;
            pal_b[i] = 8'd0;
            pal_a[i] = 8'd255;
        end
        count_model = 256;
    end

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n) begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                if (pending_index.size() == 0) begin
                    note_error($sformatf("unexpected result best_index=%0d", m_axis_tdata));
                end else begin
                    want = pending_index.pop_front();
                    if (m_axis_tdata !== want) begin
                        note_error($sformatf("best_index expected %0d actual %0d",
                                             want, m_axis_tdata));
                    end
                end
            end
            if (i_cfg_wen) begin
                count_model = 32'(i_cfg_wdata);
            end
            if (s_axis_tvalid && s_axis_tready === 1'b1) begin
                if (s_axis_tuser == pncs_pkg::OP_WRITE) begin
                    pal_r[s_axis_tdata[7:0]] = s_axis_tdata[15:8];
                    pal_g[s_axis_tdata[7:0]] = s_axis_tdata[23:16];
                    pal_b[s_axis_tdata[7:0]] = s_axis_tdata[31:24];
                    pal_a[s_axis_tdata[7:0]] = s_axis_tdata[39:32];
                end else if (req_typed) begin
                    pending_index.push_back(req_res);
                end else begin
                    pending_index.push_back(nearest_index(s_axis_tdata[15:8], s_axis_tdata[23:16],
                                                          s_axis_tdata[31:24], s_axis_tdata[39:32],
                                                          s_axis_tdata[48:40]));
                end
            end
        end
    end

    // Holds one request on the bus until it is taken; tvalid stays high afterwards.
    task automatic send_request(input logic op, input logic [7:0] idx, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b, input logic [7:0] a,
                                input logic [8:0] mask, input logic typed,
                                input logic [7:0] res);
        while (!calm && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, mask, a, b, g, r, idx};
        req_typed     <= typed;
        req_res       <= res;
        do begin
            @(posedge i_clk);
        end while (s_axis_tready !== 1'b1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_index.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_count(input logic [8:0] cnt);
        wait_drained();
        repeat (CFG_GAP) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin
        logic [8:0]  set_counts [9];
        logic [8:0]  mask;
        logic [7:0]  idx, qa;
        int unsigned lim;
        t_dir_row    row;
        set_counts = '{9'd256, 9'd0, 9'd2, 9'd37, 9'd511, 9'd1, 9'd300, 9'd256, 9'd130};
        set_counts[8] = 9'($urandom_range(3, 255));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++) begin
            row = DIR_ROWS[k];
            if (row.kind == ROW_CFG) begin
                set_count(row.cnt);
            end else begin
                send_request((row.kind == ROW_WRITE) ? pncs_pkg::OP_WRITE : pncs_pkg::OP_QUERY,
                             row.idx, row.r, row.g, row.b, row.a, row.mask, row.typed,
                             row.res);
            end
        end

        for (int s = 0; s < 9; s++) begin
            set_count(set_counts[s]);
            calm = (s == 3);
            lim = (set_counts[s] > 256) ? 256 : set_counts[s];
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if ($urandom_range(99) < 40) begin
                    idx = (lim > 0 && $urandom_range(1)) ? 8'($urandom_range(lim - 1))
                                                          : 8'($urandom_range(255));
                    send_request(pncs_pkg::OP_WRITE, idx, 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom), 9'($urandom), 1'b0, 8'd0);
                end else begin
                    case ($urandom_range(3))
                        0: mask = $urandom_range(1) ? NO_MASK : {1'b1, 8'($urandom)};
                        1: mask = (lim > 0) ? 9'($urandom_range(lim - 1)) : 9'($urandom_range(255));
                        default: mask = 9'($urandom_range(255));
                    endcase
                    qa = ($urandom_range(3) == 0) ? 8'($urandom_range(7)) : 8'($urandom);
                    send_request(pncs_pkg::OP_QUERY, 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), qa, mask, 1'b0, 8'd0);
                end
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending_index.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
